>>> design/bed_pkg.sv
package bed_pkg;

	localparam int BED_QUEUE_DEPTH = 4;
	localparam int BED_MAX_RES     = 3;

	typedef struct packed {
		logic [1:0]                   cnt;
		logic [BED_MAX_RES-1:0][7:0]  bytes;
		logic                         str_end;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t data;
	} qwr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

>>> design/backslash_escape_decoder_core.sv
// Path: the results of an input word are registered in the queue and leave from its head.
// Throughput: one input word per cycle unless full; one result word per cycle on pop;
// a queue of QUEUE_DEPTH result groups (up to three words each) sets how far input runs ahead.
// Reset (arst_n low, asynchronous): decoding disabled, parser in plain text, queue empty.
module backslash_escape_decoder_core #(
	parameter int QUEUE_DEPTH = bed_pkg::BED_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       string_end,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_last
);
	import bed_pkg::*;

	qwr_t    q_wr;
	qstat_t  q_stat;
	bundle_t head;
	logic    q_pop;

	bed_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.in_byte    (in_byte),
		.string_end (string_end),
		.q_stat     (q_stat),
		.q_wr       (q_wr)
	);

	bed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_pop  (q_pop),
		.q_stat (q_stat),
		.head   (head)
	);

	bed_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.string_last (string_last)
	);

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_wr.valid)
		else $error("queue written while full");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	a_str_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && string_last) |-> run_last)
		else $error("string_last without run_last");

	a_idle_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.empty && !q_wr.valid) |=> q_stat.empty)
		else $error("queue filled without a write");
`endif

endmodule

>>> design/bed_front.sv
module bed_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data,
	input  logic           push,
	output logic           full,
	input  logic [7:0]     in_byte,
	input  logic           string_end,
	input  bed_pkg::qstat_t q_stat,
	output bed_pkg::qwr_t  q_wr
);
	import bed_pkg::*;

	localparam logic [2:0] PH_NORMAL = 3'd0;
	localparam logic [2:0] PH_ESC    = 3'd1;
	localparam logic [2:0] PH_HEX1   = 3'd2;
	localparam logic [2:0] PH_HEX2   = 3'd3;
	localparam logic [2:0] PH_OCT    = 3'd4;

	localparam logic [7:0] BSLASH   = 8'h5C;
	localparam logic [7:0] ESC_CODE = 8'h1B;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_X     = 8'h78;

	function automatic bundle_t emit(bundle_t a, logic [7:0] x);
		bundle_t r;
		r = a;
		case (a.cnt)
			2'd0: r.bytes[0] = x;
			2'd1: r.bytes[1] = x;
			2'd2: r.bytes[2] = x;
			default: ;
		endcase
		if (a.cnt != 2'd3)
			r.cnt = a.cnt + 2'd1;
		return r;
	endfunction

	function automatic bundle_t flush(bundle_t a, logic [2:0] ph, logic [7:0] pv);
		bundle_t r;
		case (ph)
			PH_ESC:  r = emit(a, BSLASH);
			PH_HEX1: r = emit(emit(a, BSLASH), CH_X);
			PH_HEX2: r = emit(a, pv);
			PH_OCT:  r = emit(a, pv);
			default: r = a;
		endcase
		return r;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_digit(logic [7:0] b);
		logic [4:0] r;
		if (b inside {[8'h30:8'h39]})
			r = {1'b1, b[3:0]};
		else if (b inside {[8'h61:8'h66], [8'h41:8'h46]})
			r = {1'b1, b[3:0] + 4'd9};
		else
			r = 5'd0;
		return r;
	endfunction

	logic       en_q;
	logic [2:0] phase_q;
	logic [7:0] pend_q;
	logic [1:0] dcnt_q;

	logic [2:0] ph_d;
	logic [7:0] pv_d;
	logic [1:0] dc_d;
	logic       fn;
	logic       oct;
	logic [4:0] hx;
	bundle_t    acc;
	logic       accept;

	assign cfg_ready = 1'b1;
	assign full      = q_stat.full;
	assign accept    = push & ~q_stat.full;

	always_comb begin
		acc         = '0;
		acc.str_end = string_end;
		ph_d        = phase_q;
		pv_d        = pend_q;
		dc_d        = dcnt_q;
		fn          = 1'b0;
		hx          = hex_digit(in_byte);
		oct         = in_byte inside {[CH_0:CH_7]};
		if (!en_q) begin
			acc  = flush(acc, phase_q, pend_q);
			ph_d = PH_NORMAL;
			acc  = emit(acc, in_byte);
		end else begin
			case (phase_q)
				PH_ESC: begin
					ph_d = PH_NORMAL;
					case (in_byte)
						CH_E:   acc = emit(acc, ESC_CODE);
						CH_F:   acc = emit(acc, 8'h0C);
						CH_N:   acc = emit(acc, 8'h0A);
						CH_R:   acc = emit(acc, 8'h0D);
						CH_T:   acc = emit(acc, 8'h09);
						CH_V:   acc = emit(acc, 8'h0B);
						BSLASH: acc = emit(acc, BSLASH);
						CH_X:   ph_d = PH_HEX1;
						CH_0: begin
							pv_d = 8'd0;
							dc_d = 2'd3;
							ph_d = PH_OCT;
						end
						default: begin
							if (oct) begin
								pv_d = {5'd0, in_byte[2:0]};
								dc_d = 2'd2;
								ph_d = PH_OCT;
							end else begin
								acc = emit(acc, BSLASH);
								acc = emit(acc, in_byte);
							end
						end
					endcase
				end
				PH_HEX1: begin
					if (hx[4]) begin
						pv_d = {4'd0, hx[3:0]};
						ph_d = PH_HEX2;
					end else begin
						acc = emit(acc, BSLASH);
						acc = emit(acc, CH_X);
						fn  = 1'b1;
					end
				end
				PH_HEX2: begin
					if (hx[4]) begin
						acc  = emit(acc, {pend_q[3:0], hx[3:0]});
						ph_d = PH_NORMAL;
					end else begin
						acc = emit(acc, pend_q);
						fn  = 1'b1;
					end
				end
				PH_OCT: begin
					if (oct) begin
						pv_d = {pend_q[4:0], in_byte[2:0]};
						dc_d = dcnt_q - 2'd1;
						if (dc_d == 2'd0) begin
							acc  = emit(acc, pv_d);
							ph_d = PH_NORMAL;
						end
					end else begin
						acc = emit(acc, pend_q);
						fn  = 1'b1;
					end
				end
				default: fn = 1'b1;
			endcase
			if (fn) begin
				ph_d = PH_NORMAL;
				if (in_byte == BSLASH) begin
					if (string_end)
						acc = emit(acc, BSLASH);
					else
						ph_d = PH_ESC;
				end else begin
					acc = emit(acc, in_byte);
				end
			end
			if (string_end) begin
				acc  = flush(acc, ph_d, pv_d);
				ph_d = PH_NORMAL;
			end
		end
	end

	assign q_wr.valid = accept && (acc.cnt != 2'd0);
	assign q_wr.data  = acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b0;
			phase_q <= PH_NORMAL;
			pend_q  <= 8'd0;
			dcnt_q  <= 2'd0;
		end else begin
			if (cfg_valid)
				en_q <= cfg_data;
			if (accept) begin
				phase_q <= ph_d;
				pend_q  <= pv_d;
				dcnt_q  <= dc_d;
			end
		end
	end

endmodule

>>> design/bed_queue.sv
module bed_queue #(
	parameter int DEPTH = bed_pkg::BED_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bed_pkg::qwr_t    q_wr,
	input  logic             q_pop,
	output bed_pkg::qstat_t  q_stat,
	output bed_pkg::bundle_t head
);
	import bed_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_wr.valid)
			mem_q[wr_ptr_q] <= q_wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_wr.valid)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (q_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			case ({q_wr.valid, q_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> design/bed_back.sv
module bed_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bed_pkg::bundle_t head,
	input  bed_pkg::qstat_t  q_stat,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             string_last
);
	import bed_pkg::*;

	logic [1:0] idx_q;
	logic       last;
	logic       take;

	assign empty       = q_stat.empty;
	assign take        = pop & ~q_stat.empty;
	assign last        = (idx_q == head.cnt - 2'd1);
	assign run_last    = last;
	assign string_last = last & head.str_end;
	assign q_pop       = take & last;

	always_comb begin
		case (idx_q)
			2'd0:    out_byte = head.bytes[0];
			2'd1:    out_byte = head.bytes[1];
			default: out_byte = head.bytes[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule
